// ----- hdl/fjr_pkg.sv -----
// ---------------------------------------------------------------------------
// fjr_pkg: shared types and constants of the frame reassembly block
// Store geometry, marker byte codes, queue entry and response types.
// ---------------------------------------------------------------------------
package fjr_pkg;

   localparam int FRAME_BYTES      = 65536;
   localparam int MAX_PACKET_BYTES = 1023;

   localparam int ADDR_W   = $clog2(FRAME_BYTES);
   localparam int CNT_W    = $clog2(FRAME_BYTES + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int POS_W    = $clog2(MAX_PACKET_BYTES + 1);
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 10;
   localparam int INDEX_W  = 16;
   localparam int FLEN_W   = 17;
   localparam int LEAD_W   = 2;
   localparam int RUN_W    = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 32;

   localparam logic [BYTE_W-1:0] MARK_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] START_ID  = 8'h50;
   localparam logic [BYTE_W-1:0] END_ID    = 8'h51;
   localparam logic [BYTE_W-1:0] EOI_BYTE  = 8'hD9;

   localparam int HEADER_BYTES = 16;
   localparam int MARK_LEN     = 4;
   localparam int MARK_HELD    = 3;

   typedef struct packed {
      logic                cmd;
      logic [BYTE_W-1:0]   data_byte;
      logic                pkt_first;
      logic [LEN_W-1:0]    pkt_length;
      logic [INDEX_W-1:0]  read_index;
   } req_type;

   typedef struct packed {
      logic                is_read;
      logic                rd_zero;
      logic [ADDR_W-1:0]   addr;
      logic [LEAD_W-1:0]   lead_ff;
      logic [RUN_W-1:0]    wr_count;
      logic [BYTE_W-1:0]   value;
      logic                frame_done;
      logic [FLEN_W-1:0]   frame_length;
      logic                overflow_drop;
   } entry_type;

   typedef struct packed {
      logic                frame_done;
      logic [FLEN_W-1:0]   frame_length;
      logic [BYTE_W-1:0]   read_byte;
      logic                overflow_drop;
   } rsp_type;

endpackage

// ----- hdl/fjr_ram.sv -----
// ---------------------------------------------------------------------------
// fjr_ram: generic single-write, single-read memory
// One write port and one read port with a registered, enabled read.
// ---------------------------------------------------------------------------
module fjr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fjr_front.sv -----
// ---------------------------------------------------------------------------
// fjr_front: packet classifier and frame bookkeeping
// Decides the kind of each packet, tracks fill level and end marker, and
// turns every accepted transaction into one queue entry.
// ---------------------------------------------------------------------------
module fjr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  fjr_pkg::req_type   req,
   output logic               req_ready,
   input  logic               queue_full,
   output logic               push,
   output fjr_pkg::entry_type push_entry
);
   import fjr_pkg::*;

   typedef enum logic [1:0] {
      KIND_UNDECIDED = 2'd0,
      KIND_START     = 2'd1,
      KIND_SKIP      = 2'd2,
      KIND_DATA      = 2'd3
   } kind_type;

   logic              in_frame_ff, in_frame_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  eoi_end_ff, eoi_end_in;
   logic              eoi_seen_ff, eoi_seen_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   kind_type          kind_ff, kind_in;

   logic              accept;
   logic              pkt_go;
   logic [POS_W-1:0]  pos_eff;
   kind_type          kind_eff;
   kind_type          kind_new;
   logic              act_store;
   logic              act_start;
   logic              act_end;
   logic              act_over;
   logic [LEAD_W-1:0] lead;
   logic              would_overflow;
   logic [RUN_W-1:0]  want;
   logic [CNT_W-1:0]  avail;
   logic [RUN_W-1:0]  run_count;
   logic              last_stored;
   logic              lead_stored;
   logic              eoi_hit;
   logic              done_now;
   logic              rd_in_range;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;
   assign pkt_go    = accept && !req.cmd;
   assign push      = accept;

   assign pos_eff  = req.pkt_first ? '0 : pos_ff;
   assign kind_eff = req.pkt_first ? KIND_UNDECIDED : kind_ff;

   assign would_overflow = ({1'b0, fill_ff} + SUM_W'(req.pkt_length)) >
                           SUM_W'(FRAME_BYTES);

   always_comb begin
      kind_new  = kind_eff;
      act_store = 1'b0;
      act_start = 1'b0;
      act_end   = 1'b0;
      act_over  = 1'b0;
      lead      = '0;
      case (kind_eff)
         KIND_UNDECIDED: begin
            if ((req.pkt_length < LEN_W'(MARK_LEN)) ||
                ((pos_eff < POS_W'(MARK_HELD)) && (req.data_byte != MARK_BYTE)) ||
                ((pos_eff >= POS_W'(MARK_HELD)) && (req.data_byte != START_ID) &&
                 (req.data_byte != END_ID))) begin
               if (!in_frame_ff) begin
                  kind_new = KIND_SKIP;
               end else if (would_overflow) begin
                  act_over = 1'b1;
                  kind_new = KIND_SKIP;
               end else begin
                  act_store = 1'b1;
                  lead      = (pos_eff >= POS_W'(MARK_HELD)) ? LEAD_W'(MARK_HELD)
                                                             : pos_eff[LEAD_W-1:0];
                  kind_new  = KIND_DATA;
               end
            end else if (pos_eff >= POS_W'(MARK_HELD)) begin
               if (req.data_byte == START_ID) begin
                  act_start = 1'b1;
                  kind_new  = KIND_START;
               end else begin
                  act_end  = 1'b1;
                  kind_new = KIND_SKIP;
               end
            end
         end
         KIND_START: begin
            act_store = (pos_eff >= POS_W'(HEADER_BYTES));
         end
         KIND_DATA: begin
            act_store = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign want        = {1'b0, lead} + RUN_W'(1);
   assign avail       = CNT_W'(FRAME_BYTES) - fill_ff;
   assign run_count   = !act_store ? '0 :
                        (avail < CNT_W'(want)) ? RUN_W'(avail) : want;
   assign last_stored = run_count > {1'b0, lead};
   assign lead_stored = (lead != '0) && (run_count != '0);
   assign eoi_hit     = last_stored && (req.data_byte == EOI_BYTE) &&
                        ((lead != '0) || (prev_ff == MARK_BYTE)) &&
                        ((fill_ff != '0) || (lead != '0));
   assign done_now    = act_end && in_frame_ff && (fill_ff != '0) && eoi_seen_ff;
   assign rd_in_range = 32'(req.read_index) < 32'(FRAME_BYTES);

   always_comb begin
      in_frame_in = in_frame_ff;
      fill_in     = fill_ff;
      eoi_end_in  = eoi_end_ff;
      eoi_seen_in = eoi_seen_ff;
      prev_in     = prev_ff;
      pos_in      = pos_ff;
      kind_in     = kind_ff;
      if (pkt_go) begin
         pos_in  = (pos_eff < POS_W'(MAX_PACKET_BYTES)) ? pos_eff + POS_W'(1) : pos_eff;
         kind_in = kind_new;
         if (act_start) begin
            fill_in     = '0;
            eoi_end_in  = '0;
            eoi_seen_in = 1'b0;
            prev_in     = '0;
            in_frame_in = 1'b1;
         end
         if (act_end || act_over) begin
            in_frame_in = 1'b0;
         end
         if (act_store) begin
            fill_in = fill_ff + CNT_W'(run_count);
            if (eoi_hit) begin
               eoi_end_in  = fill_ff + CNT_W'(lead) + CNT_W'(1);
               eoi_seen_in = 1'b1;
            end
            if (last_stored) begin
               prev_in = req.data_byte;
            end else if (lead_stored) begin
               prev_in = MARK_BYTE;
            end
         end
      end
   end

   always_comb begin
      push_entry.is_read       = req.cmd;
      push_entry.rd_zero       = req.cmd && !rd_in_range;
      push_entry.addr          = req.cmd ? ADDR_W'(req.read_index) : fill_ff[ADDR_W-1:0];
      push_entry.lead_ff       = lead;
      push_entry.wr_count      = req.cmd ? '0 : run_count;
      push_entry.value         = req.data_byte;
      push_entry.frame_done    = !req.cmd && done_now;
      push_entry.frame_length  = (!req.cmd && done_now) ? FLEN_W'(eoi_end_ff) : '0;
      push_entry.overflow_drop = !req.cmd && act_over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         fill_ff     <= '0;
         eoi_end_ff  <= '0;
         eoi_seen_ff <= 1'b0;
         prev_ff     <= '0;
         pos_ff      <= '0;
         kind_ff     <= KIND_UNDECIDED;
      end else begin
         in_frame_ff <= in_frame_in;
         fill_ff     <= fill_in;
         eoi_end_ff  <= eoi_end_in;
         eoi_seen_ff <= eoi_seen_in;
         prev_ff     <= prev_in;
         pos_ff      <= pos_in;
         kind_ff     <= kind_in;
      end
   end

endmodule

// ----- hdl/fjr_queue.sv -----
// ---------------------------------------------------------------------------
// fjr_queue: short entry queue between classifier and store engine
// A small first-in first-out buffer that decouples the two sides.
// ---------------------------------------------------------------------------
module fjr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fjr_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output fjr_pkg::entry_type head
);
   import fjr_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/fjr_back.sv -----
// ---------------------------------------------------------------------------
// fjr_back: frame store engine and response register
// Writes queued byte runs into the store one byte per cycle, except that the
// last byte of a run waits while the response register is held; serves reads,
// and holds each response until the downstream side takes it.
module fjr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  fjr_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fjr_pkg::rsp_type   rsp
);
   import fjr_pkg::*;

   logic [RUN_W-1:0]  step_ff, step_in;
   logic              valid_ff, valid_in;
   logic              done_ff;
   logic [FLEN_W-1:0] length_ff;
   logic              over_ff;
   logic              rd_ok_ff;

   logic              last;
   logic              advance;
   logic              move;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [BYTE_W-1:0] rd_data;

   assign last    = head.is_read || ((step_ff + RUN_W'(1)) >= head.wr_count);
   assign advance = !valid_ff || rsp_ready;
   assign move    = head_valid && (!last || advance);
   assign pop     = head_valid && last && advance;

   assign wr_en   = move && !head.is_read && (step_ff < head.wr_count);
   assign wr_addr = head.addr + ADDR_W'(step_ff);
   assign wr_data = (step_ff < {1'b0, head.lead_ff}) ? MARK_BYTE : head.value;
   assign rd_en   = head_valid && head.is_read && advance;

   fjr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head.addr),
      .rd_data (rd_data)
   );

   always_comb begin
      step_in = step_ff;
      if (pop) begin
         step_in = '0;
      end else if (move) begin
         step_in = step_ff + RUN_W'(1);
      end
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         done_ff   <= head.frame_done;
         length_ff <= head.frame_length;
         over_ff   <= head.overflow_drop;
         rd_ok_ff  <= head.is_read && !head.rd_zero;
      end
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp.frame_done    = done_ff;
   assign rsp.frame_length  = length_ff;
   assign rsp.read_byte     = rd_ok_ff ? rd_data : '0;
   assign rsp.overflow_drop = over_ff;

endmodule

// ----- hdl/iso_jpeg_frame_reassembly_top.sv -----
// ---------------------------------------------------------------------------
// iso_jpeg_frame_reassembly_top: isochronous JPEG frame reassembly
// Classifies packet bytes, assembles frames in a byte store, reports the
// trimmed frame length at an end packet after an EOI marker and serves store reads.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  req      in         req_tvalid / req_tready  req_tuser, req_tdata[39:0]
//  rsp      out        rsp_tvalid / rsp_tready  rsp_tdata[31:0]
//
// One transaction per cycle is accepted while the queue is not full; every
// transaction yields one response, through the queue and the response register.
// A data packet decided after its leading FF bytes writes those bytes as well,
// up to three extra bytes on the single store write port. Synchronous reset
// clears control state only; the store is not cleared. A four-entry queue lets
// the input keep accepting while a response waits on rsp_tready.
// ---------------------------------------------------------------------------
module iso_jpeg_frame_reassembly_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // data_byte[7:0], pkt_first[8], pkt_length[18:9], read_index[34:19], zeros
   input  logic [fjr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // cmd[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // frame_done[0], frame_length[17:1], read_byte[25:18], overflow_drop[26], zeros
   output logic [fjr_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import fjr_pkg::*;

   req_type   req;
   entry_type push_entry;
   entry_type head;
   rsp_type   rsp;
   logic      queue_full;
   logic      push;
   logic      pop;
   logic      head_valid;

   assign req.cmd        = req_tuser;
   assign req.data_byte  = req_tdata[7:0];
   assign req.pkt_first  = req_tdata[8];
   assign req.pkt_length = req_tdata[18:9];
   assign req.read_index = req_tdata[34:19];

   fjr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req        (req),
      .req_ready  (req_tready),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   fjr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   fjr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {5'd0, rsp.overflow_drop, rsp.read_byte, rsp.frame_length,
                       rsp.frame_done};

`ifndef SYNTHESIS
   a_done_over_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp.frame_done && rsp.overflow_drop))
      else $error("Frame completion and overflow drop in the same response.");

   a_length_only_when_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp.frame_done) |-> (rsp.frame_length == '0))
      else $error("Frame length reported without a completed frame.");

   a_no_read_byte_on_events: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp.frame_done || rsp.overflow_drop)) |-> (rsp.read_byte == '0))
      else $error("Read byte present in a packet byte response.");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("Queue popped while empty.");
`endif

endmodule
